@@ rtl/todt_pkg.sv @@
// Package for the timestamp ordered defer table: sizes, operation and status codes.
// No dependencies.
`default_nettype none
package todt_pkg;
    localparam int CAPACITY = 16;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = 5;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_LOOKUP   = 3'd2,
        OP_SMALLEST = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    localparam logic [4:0] POS_NONE = 5'h1f;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] seq_number;
        logic [31:0] recv_time;
        logic [31:0] payload_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] tag_out;
        logic [31:0] time_out;
        logic [4:0]  position;
        logic [4:0]  fill_count;
        logic        is_full;
    } rsp_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] tstamp;
        logic [31:0] tag;
    } entry_t;
endpackage
`default_nettype wire

@@ rtl/todt_if.sv @@
// Valid/ready channel interfaces for the defer table.
// Depends on todt_pkg.
`default_nettype none
interface todt_req_if;
    logic           valid;
    logic           ready;
    todt_pkg::req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface todt_rsp_if;
    logic           valid;
    logic           ready;
    todt_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface todt_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/timestamp_ordered_defer_table.sv @@
// Timestamp ordered defer table: 16-entry table in one synchronous memory, depends on
// todt_pkg and todt_if. An accepted word passes through a scan of the stored entries, a
// decide state, a read and a write for each shifted entry on add/remove, and an output
// state that returns the result.
// Throughput: one word at a time; the next word is taken once idle, even while a result waits.
// Reset: count cleared, max_entries = 16; memory contents are not cleared.
`default_nettype none
module timestamp_ordered_defer_table (
    input  wire logic  clk,
    input  wire logic  rst_n,
    todt_req_if.sink   in_ch,
    todt_rsp_if.source out_ch,
    todt_cfg_if.sink   cfg
);
    localparam int IW = todt_pkg::IDX_W;
    localparam int CW = todt_pkg::CNT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DEC   = 6'b000100,
        S_SHRD  = 6'b001000,
        S_SHWR  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    todt_pkg::entry_t mem [todt_pkg::CAPACITY];
    todt_pkg::entry_t rd_q;
    logic             mem_we;
    logic [IW-1:0]    wr_addr, rd_addr;
    todt_pkg::entry_t wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [4:0]       max_reg;
    todt_pkg::req_t   req_reg, req_next;
    logic [CW-1:0]    idx_reg, idx_next;       // address issued in scan
    logic             rdv_reg, rdv_next;       // rd_q valid for idx_reg-1
    logic [CW-1:0]    ins_reg, ins_next;       // add: first entry with later time
    logic             hit_reg, hit_next;
    logic [CW-1:0]    at_reg, at_next;
    todt_pkg::entry_t best_reg, best_next;
    logic [CW-1:0]    sh_reg, sh_next;         // shift cursor
    todt_pkg::rsp_t   rsp_reg, rsp_next;
    logic             ov_reg, ov_next;

    logic [CW-1:0] limit;
    logic [CW-1:0] cur;
    logic          full_now;
    logic [CW-1:0] cnt_after;

    assign limit = (max_reg < CW'(todt_pkg::CAPACITY)) ? max_reg : CW'(todt_pkg::CAPACITY);
    assign cur   = idx_reg - CW'(1);
    assign full_now = count_reg >= limit;

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        req_next   = req_reg;
        idx_next   = idx_reg;
        rdv_next   = 1'b0;
        ins_next   = ins_reg;
        hit_next   = hit_reg;
        at_next    = at_reg;
        best_next  = best_reg;
        sh_next    = sh_reg;
        rsp_next   = rsp_reg;
        ov_next    = ov_reg;
        mem_we     = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        rd_addr    = idx_reg[IW-1:0];
        cnt_after  = count_reg;
        if (out_ch.ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    req_next   = in_ch.data;
                    idx_next   = '0;
                    ins_next   = count_reg;
                    hit_next   = 1'b0;
                    at_next    = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // consume the word read last cycle
                if (rdv_reg)
                begin
                    if (rd_q.seq == req_reg.seq_number && !hit_reg &&
                        req_reg.operation != todt_pkg::OP_SMALLEST)
                    begin
                        hit_next  = 1'b1;
                        at_next   = cur;
                        best_next = rd_q;
                    end
                    if (req_reg.operation == todt_pkg::OP_ADD && ins_reg == count_reg &&
                        rd_q.tstamp > req_reg.recv_time)
                        ins_next = cur;
                    if (req_reg.operation == todt_pkg::OP_SMALLEST &&
                        (cur == '0 || rd_q.seq < best_reg.seq))
                    begin
                        best_next = rd_q;
                        at_next   = cur;
                    end
                end
                if (idx_reg < count_reg)
                begin
                    rd_addr  = idx_reg[IW-1:0];
                    rdv_next = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
                else if (!rdv_reg)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                state_next = S_OUT;
                if (req_reg.operation == todt_pkg::OP_ADD && !full_now && !hit_reg)
                begin
                    sh_next = count_reg;
                    if (count_reg != ins_reg)
                        state_next = S_SHRD;
                end
                else if (req_reg.operation == todt_pkg::OP_REMOVE && hit_reg)
                begin
                    sh_next = at_reg;
                    if (at_reg + CW'(1) < count_reg)
                        state_next = S_SHRD;
                end
            end
            S_SHRD:
            begin
                // add moves sh-1 up to sh; remove moves sh+1 down to sh
                if (req_reg.operation == todt_pkg::OP_ADD)
                    rd_addr = IW'(sh_reg - CW'(1));
                else
                    rd_addr = IW'(sh_reg + CW'(1));
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                mem_we  = 1'b1;
                wr_addr = sh_reg[IW-1:0];
                wr_data = rd_q;
                if (req_reg.operation == todt_pkg::OP_ADD)
                begin
                    sh_next = sh_reg - CW'(1);
                    state_next = (sh_reg - CW'(1) == ins_reg) ? S_OUT : S_SHRD;
                end
                else
                begin
                    sh_next = sh_reg + CW'(1);
                    state_next = (sh_reg + CW'(2) >= count_reg) ? S_OUT : S_SHRD;
                end
            end
            S_OUT:
            begin
                // hold here while the previous result still waits
                if (!ov_reg || out_ch.ready)
                begin
                    rsp_next = '0;
                    rsp_next.position = todt_pkg::POS_NONE;
                    case (req_reg.operation)
                        todt_pkg::OP_ADD:
                        begin
                            if (full_now)
                                rsp_next.status = todt_pkg::ST_FULL;
                            else if (hit_reg)
                                rsp_next.status = todt_pkg::ST_DUP;
                            else
                            begin
                                mem_we    = 1'b1;
                                wr_addr   = ins_reg[IW-1:0];
                                wr_data   = '{seq: req_reg.seq_number,
                                              tstamp: req_reg.recv_time,
                                              tag: req_reg.payload_tag};
                                cnt_after = count_reg + CW'(1);
                            end
                        end
                        todt_pkg::OP_REMOVE, todt_pkg::OP_LOOKUP:
                        begin
                            if (hit_reg)
                            begin
                                rsp_next.found    = 1'b1;
                                rsp_next.tag_out  = best_reg.tag;
                                rsp_next.time_out = best_reg.tstamp;
                                if (req_reg.operation == todt_pkg::OP_REMOVE)
                                    cnt_after = count_reg - CW'(1);
                            end
                            else
                                rsp_next.status = todt_pkg::ST_MISS;
                        end
                        todt_pkg::OP_SMALLEST:
                        begin
                            if (count_reg == '0)
                                rsp_next.status = todt_pkg::ST_MISS;
                            else
                            begin
                                rsp_next.position = at_reg;
                                rsp_next.tag_out  = best_reg.tag;
                                rsp_next.time_out = best_reg.tstamp;
                            end
                        end
                        todt_pkg::OP_CLEAR:
                            cnt_after = '0;
                        default:
                            cnt_after = count_reg;
                    endcase
                    count_next          = cnt_after;
                    rsp_next.fill_count = cnt_after;
                    rsp_next.is_full    = cnt_after >= limit;
                    ov_next             = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            max_reg   <= 5'd16;
            ov_reg    <= 1'b0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            rdv_reg   <= rdv_next;
            if (cfg.valid)
                max_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        idx_reg  <= idx_next;
        ins_reg  <= ins_next;
        hit_reg  <= hit_next;
        at_reg   <= at_next;
        best_reg <= best_next;
        sh_reg   <= sh_next;
        rsp_reg  <= rsp_next;
    end
endmodule
`default_nettype wire
